@@ rtl/cwpc_pkg.sv @@
package cwpc_pkg;

  localparam int COIL_COUNT_DEF = 118;
  localparam int REG_COUNT_DEF  = 224;
  localparam int CFG_IDX_W      = 8;

  // command codes
  localparam logic [3:0] CMD_WCOIL  = 4'd0;
  localparam logic [3:0] CMD_RCOIL  = 4'd1;
  localparam logic [3:0] CMD_WREG   = 4'd2;
  localparam logic [3:0] CMD_RREG   = 4'd3;
  localparam logic [3:0] CMD_RREG32 = 4'd4;
  localparam logic [3:0] CMD_TICK   = 4'd5;
  localparam logic [3:0] CMD_ABORT  = 4'd6;
  localparam logic [3:0] CMD_PULSE  = 4'd7;
  localparam logic [3:0] CMD_STUCK  = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_FAULT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL      = 8'd1;

  // coil indexes
  localparam int CO_ESTOP     = 0;
  localparam int CO_MANUAL    = 1;
  localparam int CO_AUTO      = 2;
  localparam int CO_RUN       = 3;
  localparam int CO_FAULT     = 14;
  localparam int CO_SCAN      = 15;
  localparam int CO_ADJUSTING = 34;
  localparam int CO_ADJ_CMD   = 43;
  localparam int CO_ADJ_OK    = 44;
  localparam int CO_ADJ_FAIL  = 45;
  localparam int CO_HOMING    = 50;
  localparam int CO_READY     = 60;
  localparam int CO_HOMED     = 61;
  localparam int CO_HMI_ESTOP = 100;
  localparam int CO_HMI_START = 101;
  localparam int CO_HMI_STOP  = 102;
  localparam int CO_HMI_RESET = 103;
  localparam int CO_MODE_SEL  = 104;

  // register indexes
  localparam logic [7:0] RG_STATUS1  = 8'd100;
  localparam logic [7:0] RG_STATUS3  = 8'd103;
  localparam logic [7:0] RG_FAULT    = 8'd110;
  localparam logic [7:0] RG_BELT     = 8'd122;
  localparam logic [7:0] RG_FREQ_LO  = 8'd126;
  localparam logic [7:0] RG_FREQ_HI  = 8'd127;
  localparam logic [7:0] RG_TARGET   = 8'd128;
  localparam logic [7:0] RG_WIDTH    = 8'd130;
  localparam logic [7:0] RG_PULSE_LO = 8'd136;
  localparam logic [7:0] RG_PULSE_HI = 8'd137;
  localparam logic [7:0] RG_HEART    = 8'd140;
  localparam logic [7:0] RG_PPMM     = 8'd204;
  localparam logic [7:0] RG_DIFF     = 8'd210;
  localparam logic [7:0] RG_LATCHED  = 8'd212;
  localparam logic [7:0] RG_ABSDIFF  = 8'd213;
  localparam logic [7:0] RG_SPEED    = 8'd220;

  localparam logic [15:0] BELT_DEF   = 16'd5000;
  localparam logic [15:0] WIDTH_DEF  = 16'd200;
  localparam logic [15:0] PPMM_DEF   = 16'd128;
  localparam logic [15:0] SPEED_MAX  = 16'd15;
  localparam logic [15:0] FREQ_FACTOR = 16'd1280;
  localparam logic [15:0] FREQ_DEF   = 16'd19200;

  localparam logic [19:0] TIMEOUT_TENTHS = 20'd300;
  localparam logic [19:0] TENTHS_MAX     = 20'hFFFFF;
  localparam logic [1:0]  HOME_SECONDS   = 2'd2;
  localparam logic [15:0] FAULT_ESTOP    = 16'd1;
  localparam logic [15:0] FAULT_TIMEOUT  = 16'd10;

  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 15;
  localparam int MOTION_W   = 21;
  localparam logic [MOTION_W-1:0] MOTION_NO_SPEED = 21'd30;

  function automatic logic coil_special(input int i);
    return i == CO_ESTOP || i == CO_MANUAL || i == CO_AUTO || i == CO_RUN ||
           i == CO_FAULT || i == CO_SCAN || i == CO_ADJUSTING || i == CO_ADJ_CMD ||
           i == CO_ADJ_OK || i == CO_ADJ_FAIL || i == CO_HOMING || i == CO_READY ||
           i == CO_HOMED || i == CO_HMI_ESTOP || i == CO_HMI_START ||
           i == CO_HMI_STOP || i == CO_HMI_RESET || i == CO_MODE_SEL;
  endfunction

endpackage

@@ rtl/conveyor_width_plc_controller_top.sv @@
// Conveyor width controller with a coil and register map.
// Input channel (in_valid_i/in_ready_o) carries one command item: command_i,
// address_i, value_i, seconds_i. Output channel (out_valid_o/out_ready_i)
// returns one item per command: read_data_o and out_of_range_o.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes home fault code
// (index 0) and stall flag (index 1); it is always ready.
// One command is in flight at a time. From accept to result a command makes
// two reads of the coil and register memories, then one step that modifies and
// writes back. A width-adjust start adds the bit-serial motion-time divider
// before the result is returned.
// The result sits in an output register; the next item is accepted while it
// waits, but that item holds in its write-back cycle until the output slot
// frees, so a stalled receiver stalls the block after one more item.
// Reset sets every register and coil to its power-up value at once: valid bits
// mark memory entries that hold written data, so no clearing pass is needed.
module conveyor_width_plc_controller_top #(
  parameter int COIL_COUNT = cwpc_pkg::COIL_COUNT_DEF,
  parameter int REG_COUNT  = cwpc_pkg::REG_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [3:0]                     command_i,
  input  logic [7:0]                     address_i,
  input  logic [15:0]                    value_i,
  input  logic [15:0]                    seconds_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [31:0]                    read_data_o,
  output logic                           out_of_range_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cwpc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);

  localparam int NW  = (COIL_COUNT + 15) / 16;
  localparam int NWB = NW * 16;
  localparam int WA  = $clog2(NW);
  localparam int AW  = $clog2(REG_COUNT);
  localparam int CI  = $clog2(COIL_COUNT);
  localparam int MW  = cwpc_pkg::MOTION_W;
  localparam logic [COIL_COUNT-1:0] SP_RST = COIL_COUNT'(1) << cwpc_pkg::CO_MANUAL;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  // held item
  logic [3:0]  cmd_q;
  logic [7:0]  addr_q;
  logic [15:0] val_q, sec_q;
  logic [7:0]  addr_b;

  // memories
  logic [15:0] cmem [NW];
  logic [15:0] dmem [REG_COUNT];
  logic [NW-1:0]        cval_q;
  logic [REG_COUNT-1:0] dval_q;
  logic [WA-1:0] craddr, craddr_q;
  logic [AW-1:0] draddr;
  logic [15:0]   cm_rd_q, dm_rd_q;
  logic          cm_rv_q, dm_rv_q;

  // special coils and registers
  logic [COIL_COUNT-1:0] sp_q, sp_mask;
  logic [NWB-1:0]        sp_pad, mask_pad;
  logic [15:0] fault_q, flo_q, fhi_q, tgt_q, wid_q, plo_q, phi_q, heart_q;
  logic [15:0] ppmm_q, diff_q, lat_q, abs_q, speed_q;
  logic [1:0]    home_left_q;
  logic [MW-1:0] motion_q;
  logic [19:0]   tenths_q;
  logic pos_act_q, tout_done_q, scan_latch_q, estop_stuck_q;
  logic [15:0] hfc_q;
  logic        stall_q;

  // captured reads
  logic [15:0] cw_merged, cw_a_q, reg_a_q, reg_b;

  // output slot
  logic        out_valid_q, oor_q;
  logic [31:0] rdata_q;
  logic        slot_free, commit, push;

  // next values
  logic [COIL_COUNT-1:0] c_d;
  logic [15:0] fault_d, flo_d, fhi_d, tgt_d, wid_d, plo_d, phi_d, heart_d;
  logic [15:0] ppmm_d, diff_d, lat_d, abs_d, speed_d;
  logic [1:0]    home_left_d;
  logic [MW-1:0] motion_d;
  logic [19:0]   tenths_d;
  logic pos_act_d, tout_done_d, scan_latch_d, estop_stuck_d;
  logic [31:0] rd_d;
  logic        oor_d, div_go, cmem_we, dmem_we;
  logic [15:0] cm_wdata;
  logic [31:0] dvd_d;
  logic [cwpc_pkg::DIVISOR_W-1:0] dsr_d;

  logic        div_done, div_rem_nz;
  logic [31:0] div_quot;

  function automatic logic [15:0] reg_pick(input logic [7:0] a, input logic [15:0] md,
                                           input logic mv);
    logic [15:0] r;
    case (a)
      cwpc_pkg::RG_FAULT:    r = fault_q;
      cwpc_pkg::RG_FREQ_LO:  r = flo_q;
      cwpc_pkg::RG_FREQ_HI:  r = fhi_q;
      cwpc_pkg::RG_TARGET:   r = tgt_q;
      cwpc_pkg::RG_WIDTH:    r = wid_q;
      cwpc_pkg::RG_PULSE_LO: r = plo_q;
      cwpc_pkg::RG_PULSE_HI: r = phi_q;
      cwpc_pkg::RG_HEART:    r = heart_q;
      cwpc_pkg::RG_PPMM:     r = ppmm_q;
      cwpc_pkg::RG_DIFF:     r = diff_q;
      cwpc_pkg::RG_LATCHED:  r = lat_q;
      cwpc_pkg::RG_ABSDIFF:  r = abs_q;
      cwpc_pkg::RG_SPEED:    r = speed_q;
      default: begin
        if (mv) begin
          r = md;
        end else if (a == cwpc_pkg::RG_BELT) begin
          r = cwpc_pkg::BELT_DEF;
        end else begin
          r = 16'h0;
        end
      end
    endcase
    return r;
  endfunction

  assign addr_b = addr_q + 8'd1;

  always_comb begin
    for (int i = 0; i < COIL_COUNT; i++) begin
      sp_mask[i] = cwpc_pkg::coil_special(i);
    end
  end
  assign sp_pad   = NWB'(sp_q & sp_mask);
  assign mask_pad = NWB'(sp_mask);

  // coil word read: status words use the low word pairs, coils use their own word
  always_comb begin
    if (state_q == S_RDA) begin
      if (cmd_q == cwpc_pkg::CMD_RREG && addr_q == cwpc_pkg::RG_STATUS1) begin
        craddr = '0;
      end else if (cmd_q == cwpc_pkg::CMD_RREG && addr_q == cwpc_pkg::RG_STATUS3) begin
        craddr = WA'(1);
      end else begin
        craddr = addr_q[WA+3:4];
      end
      draddr = addr_q[AW-1:0];
    end else begin
      craddr = WA'(2);
      draddr = addr_b[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    cm_rd_q  <= cmem[craddr];
    dm_rd_q  <= dmem[draddr];
    craddr_q <= craddr;
    if (cmem_we && commit) begin
      cmem[addr_q[WA+3:4]] <= cm_wdata;
    end
    if (dmem_we && commit) begin
      dmem[addr_q[AW-1:0]] <= val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cm_rv_q <= 1'b0;
      dm_rv_q <= 1'b0;
    end else begin
      cm_rv_q <= cval_q[craddr];
      dm_rv_q <= dval_q[draddr];
    end
  end

  assign cw_merged = ((cm_rv_q ? cm_rd_q : 16'h0) & ~mask_pad[craddr_q*16 +: 16]) |
                     sp_pad[craddr_q*16 +: 16];
  assign reg_b     = reg_pick(addr_b, dm_rd_q, dm_rv_q);

  assign slot_free = !out_valid_q || out_ready_i;
  assign commit    = (state_q == S_EXEC) && slot_free;
  assign push      = (commit && !div_go) || (state_q == S_DONE && slot_free);

  always_comb begin : exec
    logic        v, old, rising, ok;
    logic [15:0] s, mag, cw3;
    logic [31:0] pulses;
    logic [20:0] tsum;
    logic [3:0]  bi;
    logic [CI-1:0] ci;
    c_d = sp_q;
    fault_d = fault_q; flo_d = flo_q; fhi_d = fhi_q; tgt_d = tgt_q; wid_d = wid_q;
    plo_d = plo_q; phi_d = phi_q; heart_d = heart_q; ppmm_d = ppmm_q; diff_d = diff_q;
    lat_d = lat_q; abs_d = abs_q; speed_d = speed_q;
    home_left_d = home_left_q; motion_d = motion_q; tenths_d = tenths_q;
    pos_act_d = pos_act_q; tout_done_d = tout_done_q; scan_latch_d = scan_latch_q;
    estop_stuck_d = estop_stuck_q;
    rd_d = '0; oor_d = 1'b0; div_go = 1'b0; cmem_we = 1'b0; dmem_we = 1'b0;
    cm_wdata = cw_a_q; dvd_d = '0; dsr_d = '0;
    v = val_q[0]; s = sec_q; bi = addr_q[3:0]; ci = addr_q[CI-1:0];
    old = cw_a_q[bi]; rising = 1'b0; ok = 1'b0; mag = '0; pulses = '0; tsum = '0;
    cw3 = '0;
    case (cmd_q)
      cwpc_pkg::CMD_WCOIL: begin
        if (addr_q > 8'(COIL_COUNT - 1)) begin
          oor_d = 1'b1;
        end else begin
          rising = v & ~old;
          c_d[ci] = v;
          cmem_we = 1'b1;
          cm_wdata[bi] = v;
          case (addr_q)
            8'(cwpc_pkg::CO_SCAN): begin
              if (rising) scan_latch_d = 1'b1;
            end
            8'(cwpc_pkg::CO_ADJ_CMD): begin
              if (rising) begin
                c_d[cwpc_pkg::CO_ADJ_OK] = 1'b0;
                c_d[cwpc_pkg::CO_ADJ_FAIL] = 1'b0;
                tenths_d = '0;
                if (c_d[cwpc_pkg::CO_ADJUSTING]) begin
                  // second press cancels
                  c_d[cwpc_pkg::CO_ADJUSTING] = 1'b0;
                  c_d[cwpc_pkg::CO_ADJ_OK] = 1'b0;
                  c_d[cwpc_pkg::CO_ADJ_FAIL] = 1'b1;
                  tenths_d = '0; pos_act_d = 1'b0; motion_d = '0;
                end else begin
                  ok = c_d[cwpc_pkg::CO_MANUAL] && c_d[cwpc_pkg::CO_HOMED] &&
                       !c_d[cwpc_pkg::CO_RUN] && !c_d[cwpc_pkg::CO_ESTOP] &&
                       !c_d[cwpc_pkg::CO_FAULT] && !c_d[cwpc_pkg::CO_HOMING] &&
                       tgt_d != wid_d;
                  if (!ok) begin
                    c_d[cwpc_pkg::CO_ADJ_FAIL] = 1'b1;
                    c_d[cwpc_pkg::CO_ADJUSTING] = 1'b0;
                  end else begin
                    lat_d  = tgt_d;
                    diff_d = tgt_d - wid_d;
                    mag    = diff_d[15] ? (16'h0 - diff_d) : diff_d;
                    abs_d  = mag;
                    pulses = $signed(diff_d) * $signed(ppmm_d);
                    plo_d  = pulses[15:0];
                    phi_d  = pulses[31:16];
                    if (speed_d != 16'h0) begin
                      div_go = 1'b1;
                      dvd_d  = mag * ppmm_d;
                      dsr_d  = cwpc_pkg::DIVISOR_W'(speed_d * cwpc_pkg::FREQ_FACTOR);
                    end else begin
                      motion_d = cwpc_pkg::MOTION_NO_SPEED;
                    end
                    c_d[cwpc_pkg::CO_ADJUSTING] = 1'b1;
                    pos_act_d = 1'b1;
                    tenths_d = '0;
                  end
                end
              end
            end
            8'(cwpc_pkg::CO_HOMING): begin
              if (rising) begin
                c_d[cwpc_pkg::CO_HOMED] = 1'b0;
                home_left_d = cwpc_pkg::HOME_SECONDS;
              end
            end
            8'(cwpc_pkg::CO_HMI_RESET): begin
              if (rising) begin
                c_d[cwpc_pkg::CO_ADJUSTING] = 1'b0;
                c_d[cwpc_pkg::CO_ADJ_OK] = 1'b0;
                c_d[cwpc_pkg::CO_ADJ_FAIL] = 1'b0;
                pos_act_d = 1'b0; motion_d = '0; tenths_d = '0;
                c_d[cwpc_pkg::CO_FAULT] = 1'b0;
                fault_d = '0;
                c_d[cwpc_pkg::CO_HOMED] = 1'b0;
                c_d[cwpc_pkg::CO_READY] = c_d[cwpc_pkg::CO_HOMED] && tgt_d == wid_d &&
                    !c_d[cwpc_pkg::CO_ESTOP] && !c_d[cwpc_pkg::CO_FAULT] && !tout_done_d;
              end
            end
            8'(cwpc_pkg::CO_MODE_SEL): begin
              if (!c_d[cwpc_pkg::CO_RUN]) begin
                c_d[cwpc_pkg::CO_AUTO] = v;
                c_d[cwpc_pkg::CO_MANUAL] = !v;
              end
            end
            8'(cwpc_pkg::CO_HMI_START): begin
              if (rising && c_d[cwpc_pkg::CO_AUTO] && c_d[cwpc_pkg::CO_READY] &&
                  !c_d[cwpc_pkg::CO_ESTOP] && !c_d[cwpc_pkg::CO_FAULT] &&
                  !c_d[cwpc_pkg::CO_RUN]) begin
                c_d[cwpc_pkg::CO_RUN] = 1'b1;
              end
            end
            8'(cwpc_pkg::CO_HMI_STOP): begin
              if (rising) c_d[cwpc_pkg::CO_RUN] = 1'b0;
            end
            8'(cwpc_pkg::CO_HMI_ESTOP): begin
              if (v) begin
                c_d[cwpc_pkg::CO_ESTOP] = 1'b1;
                c_d[cwpc_pkg::CO_FAULT] = 1'b1;
                fault_d = cwpc_pkg::FAULT_ESTOP;
                c_d[cwpc_pkg::CO_RUN] = 1'b0;
                if (pos_act_d || c_d[cwpc_pkg::CO_ADJUSTING]) begin
                  c_d[cwpc_pkg::CO_ADJUSTING] = 1'b0;
                  c_d[cwpc_pkg::CO_ADJ_OK] = 1'b0;
                  c_d[cwpc_pkg::CO_ADJ_FAIL] = 1'b1;
                  tenths_d = '0; pos_act_d = 1'b0; motion_d = '0;
                end
              end else if (!estop_stuck_d) begin
                c_d[cwpc_pkg::CO_ESTOP] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      cwpc_pkg::CMD_RCOIL: begin
        if (addr_q > 8'(COIL_COUNT - 1)) oor_d = 1'b1;
        else rd_d = {31'h0, old};
      end
      cwpc_pkg::CMD_WREG: begin
        if (addr_q > 8'(REG_COUNT - 1)) begin
          oor_d = 1'b1;
        end else if (addr_q != cwpc_pkg::RG_STATUS1 && addr_q != cwpc_pkg::RG_STATUS3) begin
          dmem_we = 1'b1;
          case (addr_q)
            cwpc_pkg::RG_FAULT:    fault_d = val_q;
            cwpc_pkg::RG_FREQ_LO:  flo_d = val_q;
            cwpc_pkg::RG_FREQ_HI:  fhi_d = val_q;
            cwpc_pkg::RG_TARGET:   tgt_d = val_q;
            cwpc_pkg::RG_WIDTH:    wid_d = val_q;
            cwpc_pkg::RG_PULSE_LO: plo_d = val_q;
            cwpc_pkg::RG_PULSE_HI: phi_d = val_q;
            cwpc_pkg::RG_HEART:    heart_d = val_q;
            cwpc_pkg::RG_PPMM:     ppmm_d = val_q;
            cwpc_pkg::RG_DIFF:     diff_d = val_q;
            cwpc_pkg::RG_LATCHED:  lat_d = val_q;
            cwpc_pkg::RG_ABSDIFF:  abs_d = val_q;
            cwpc_pkg::RG_SPEED:    speed_d = val_q;
            default: begin
            end
          endcase
          if (addr_q == cwpc_pkg::RG_TARGET || addr_q == cwpc_pkg::RG_WIDTH) begin
            diff_d = tgt_d - wid_d;
            if (tgt_d == wid_d) tout_done_d = 1'b0;
            c_d[cwpc_pkg::CO_READY] = c_d[cwpc_pkg::CO_HOMED] && tgt_d == wid_d &&
                !c_d[cwpc_pkg::CO_ESTOP] && !c_d[cwpc_pkg::CO_FAULT] && !tout_done_d;
          end
          if (addr_q == cwpc_pkg::RG_SPEED) begin
            if (speed_d > cwpc_pkg::SPEED_MAX) speed_d = cwpc_pkg::SPEED_MAX;
            flo_d = speed_d * cwpc_pkg::FREQ_FACTOR;
            fhi_d = 16'h0;
          end
        end
      end
      cwpc_pkg::CMD_RREG: begin
        if (addr_q > 8'(REG_COUNT - 1)) begin
          oor_d = 1'b1;
        end else if (addr_q == cwpc_pkg::RG_STATUS1) begin
          cw3 = cw_a_q & 16'h7FFF;
          cw3[8] = cw3[8] | sp_q[cwpc_pkg::CO_READY];
          cw3[9] = cw3[9] | sp_q[cwpc_pkg::CO_HOMED];
          rd_d = {16'h0, cw3};
        end else if (addr_q == cwpc_pkg::RG_STATUS3) begin
          rd_d = {16'h0, cw_merged[13:0], cw_a_q[15:14]};
        end else begin
          rd_d = {16'h0, reg_a_q};
        end
      end
      cwpc_pkg::CMD_RREG32: begin
        if (addr_q > 8'(REG_COUNT - 2)) oor_d = 1'b1;
        else rd_d = {reg_b, reg_a_q};
      end
      cwpc_pkg::CMD_TICK: begin
        heart_d = heart_q + s;
        if (c_d[cwpc_pkg::CO_HOMING]) begin
          if (s >= {14'h0, home_left_d}) begin
            c_d[cwpc_pkg::CO_HOMING] = 1'b0;
            home_left_d = '0;
            if (hfc_q != 16'h0) begin
              c_d[cwpc_pkg::CO_HOMED] = 1'b0;
              c_d[cwpc_pkg::CO_FAULT] = 1'b1;
              fault_d = hfc_q;
            end else begin
              c_d[cwpc_pkg::CO_HOMED] = 1'b1;
              wid_d = '0;
              diff_d = tgt_d - wid_d;
            end
            c_d[cwpc_pkg::CO_READY] = c_d[cwpc_pkg::CO_HOMED] && tgt_d == wid_d &&
                !c_d[cwpc_pkg::CO_ESTOP] && !c_d[cwpc_pkg::CO_FAULT] && !tout_done_d;
          end else begin
            home_left_d = home_left_d - s[1:0];
          end
        end
        if (pos_act_d) begin
          tsum = {1'b0, tenths_d} + 21'(s * 20'd10);
          tenths_d = (tsum > {1'b0, cwpc_pkg::TENTHS_MAX}) ? cwpc_pkg::TENTHS_MAX : tsum[19:0];
          if (!stall_q && {5'h0, s} >= motion_d) begin
            c_d[cwpc_pkg::CO_ADJUSTING] = 1'b0;
            wid_d = tgt_d;
            diff_d = tgt_d - wid_d;
            c_d[cwpc_pkg::CO_ADJ_FAIL] = 1'b0;
            c_d[cwpc_pkg::CO_ADJ_OK] = 1'b1;
            pos_act_d = 1'b0; motion_d = '0; tenths_d = '0;
          end else if (tenths_d >= cwpc_pkg::TIMEOUT_TENTHS) begin
            c_d[cwpc_pkg::CO_ADJUSTING] = 1'b0;
            c_d[cwpc_pkg::CO_ADJ_OK] = 1'b0;
            c_d[cwpc_pkg::CO_ADJ_FAIL] = 1'b1;
            c_d[cwpc_pkg::CO_FAULT] = 1'b1;
            fault_d = cwpc_pkg::FAULT_TIMEOUT;
            tout_done_d = 1'b1;
            pos_act_d = 1'b0; motion_d = '0; tenths_d = '0;
          end else if (!stall_q) begin
            motion_d = motion_d - {5'h0, s};
          end
        end
        if (tgt_d == wid_d) tout_done_d = 1'b0;
        c_d[cwpc_pkg::CO_READY] = c_d[cwpc_pkg::CO_HOMED] && tgt_d == wid_d &&
            !c_d[cwpc_pkg::CO_ESTOP] && !c_d[cwpc_pkg::CO_FAULT] && !tout_done_d;
      end
      cwpc_pkg::CMD_ABORT: begin
        if (pos_act_d || c_d[cwpc_pkg::CO_ADJUSTING]) begin
          c_d[cwpc_pkg::CO_ADJUSTING] = 1'b0;
          c_d[cwpc_pkg::CO_ADJ_OK] = 1'b0;
          c_d[cwpc_pkg::CO_ADJ_FAIL] = 1'b1;
          tenths_d = '0; pos_act_d = 1'b0; motion_d = '0;
        end
      end
      cwpc_pkg::CMD_PULSE: begin
        rd_d = {31'h0, scan_latch_q};
        scan_latch_d = 1'b0;
      end
      cwpc_pkg::CMD_STUCK: begin
        estop_stuck_d = v;
        if (v) c_d[cwpc_pkg::CO_ESTOP] = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_RDA;
      S_RDA:  state_d = S_RDB;
      S_RDB:  state_d = S_EXEC;
      S_EXEC: if (slot_free) state_d = div_go ? S_DIV : S_IDLE;
      S_DIV:  if (div_done) state_d = S_DONE;
      S_DONE: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= command_i;
      addr_q <= address_i;
      val_q  <= value_i;
      sec_q  <= seconds_i;
    end
    if (state_q == S_RDB) begin
      cw_a_q  <= cw_merged;
      reg_a_q <= reg_pick(addr_q, dm_rd_q, dm_rv_q);
    end
    if (push) begin
      rdata_q <= (state_q == S_DONE) ? 32'h0 : rd_d;
      oor_q   <= (state_q == S_DONE) ? 1'b0 : oor_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      cval_q        <= '0;
      dval_q        <= '0;
      sp_q          <= SP_RST;
      fault_q       <= '0;
      flo_q         <= cwpc_pkg::FREQ_DEF;
      fhi_q         <= '0;
      tgt_q         <= cwpc_pkg::WIDTH_DEF;
      wid_q         <= cwpc_pkg::WIDTH_DEF;
      plo_q         <= '0;
      phi_q         <= '0;
      heart_q       <= '0;
      ppmm_q        <= cwpc_pkg::PPMM_DEF;
      diff_q        <= '0;
      lat_q         <= '0;
      abs_q         <= '0;
      speed_q       <= cwpc_pkg::SPEED_MAX;
      home_left_q   <= '0;
      motion_q      <= '0;
      tenths_q      <= '0;
      pos_act_q     <= 1'b0;
      tout_done_q   <= 1'b0;
      scan_latch_q  <= 1'b0;
      estop_stuck_q <= 1'b0;
      hfc_q         <= '0;
      stall_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          cwpc_pkg::CFG_HOME_FAULT: hfc_q <= cfg_data_i;
          cwpc_pkg::CFG_STALL:      stall_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (commit) begin
        if (cmem_we) cval_q[addr_q[WA+3:4]] <= 1'b1;
        if (dmem_we) dval_q[addr_q[AW-1:0]] <= 1'b1;
        sp_q          <= c_d;
        fault_q       <= fault_d;
        flo_q         <= flo_d;
        fhi_q         <= fhi_d;
        tgt_q         <= tgt_d;
        wid_q         <= wid_d;
        plo_q         <= plo_d;
        phi_q         <= phi_d;
        heart_q       <= heart_d;
        ppmm_q        <= ppmm_d;
        diff_q        <= diff_d;
        lat_q         <= lat_d;
        abs_q         <= abs_d;
        speed_q       <= speed_d;
        home_left_q   <= home_left_d;
        motion_q      <= motion_d;
        tenths_q      <= tenths_d;
        pos_act_q     <= pos_act_d;
        tout_done_q   <= tout_done_d;
        scan_latch_q  <= scan_latch_d;
        estop_stuck_q <= estop_stuck_d;
      end else if (state_q == S_DIV && div_done) begin
        // ceiling of the quotient
        motion_q <= MW'(div_quot + {31'h0, div_rem_nz});
      end
    end
  end

  cwpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (commit && div_go),
    .dividend_i (dvd_d),
    .divisor_i  (dsr_d),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_nz_o   (div_rem_nz)
  );

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign read_data_o    = rdata_q;
  assign out_of_range_o = oor_q;
  assign cfg_ready_o    = 1'b1;

endmodule

@@ rtl/cwpc_div.sv @@
module cwpc_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [cwpc_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  logic [cwpc_pkg::DIVISOR_W-1:0]   divisor_i,
  output logic                             done_o,
  output logic [cwpc_pkg::DIVIDEND_W-1:0]  quot_o,
  output logic                             rem_nz_o
);

  localparam int NW = cwpc_pkg::DIVIDEND_W;
  localparam int DW = cwpc_pkg::DIVISOR_W;
  localparam int CW = $clog2(NW);

  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, dsr_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   diff;

  assign trial = {rem_q, quo_q[NW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done_o   = done_q;
  assign quot_o   = quo_q;
  assign rem_nz_o = |rem_q;

endmodule

@@ rtl/cwpc_chk.sv @@
module cwpc_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [31:0]                    read_data_o,
  input logic                           out_of_range_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [cwpc_pkg::CFG_IDX_W-1:0] cfg_index_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) &&
    $stable(out_of_range_o))
    else $error("result changed while stalled");

  // an ignored access never returns data
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> read_data_o == 32'h0)
    else $error("out-of-range item carries data");

  // one command in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while busy");

  // a configuration write to the stall flag is never back-pressured
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i == cwpc_pkg::CFG_STALL |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind conveyor_width_plc_controller_top cwpc_chk u_cwpc_chk (.*);
